>>> src/wmf_pkg.sv
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared types and constants for the window median filter.
// ----------------------------------------------------------------------------
package wmf_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int WLEN_W         = 5;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 5;
  localparam int DEF_MAX_WINDOW = 32;
  localparam int MEDIAN_DIV     = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 1'b1;

  // input word action codes
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // broadcast control for the row of cells
  typedef struct packed {
    logic    load;    // write sample into the cell at the write position
    logic    sort;    // one odd-even compare-exchange phase
    logic    phase;   // parity of the lower cell of each pair
    sample_t sample;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SORT = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

>>> src/wmf_in_if.sv
// ----------------------------------------------------------------------------
// wmf_in_if
// Input channel: sample and query words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface wmf_in_if;
  logic             valid;
  logic             ready;
  logic             action;
  wmf_pkg::sample_t sample_value;

  modport source (output valid, output action, output sample_value, input ready);
  modport sink   (input valid, input action, input sample_value, output ready);
endinterface

>>> src/wmf_out_if.sv
// ----------------------------------------------------------------------------
// wmf_out_if
// Result channel: median words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface wmf_out_if;
  logic             valid;
  logic             ready;
  wmf_pkg::sample_t median_value;

  modport source (output valid, output median_value, input ready);
  modport sink   (input valid, input median_value, output ready);
endinterface

>>> src/wmf_cell.sv
// ----------------------------------------------------------------------------
// wmf_cell
// One window slot: loads a sample when addressed, or takes the min/max of
// itself and a neighbor during an odd-even transposition phase.
// ----------------------------------------------------------------------------
module wmf_cell #(
  parameter int IDX   = 0,
  parameter int PW    = 5,
  parameter int LEN_W = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wmf_pkg::cell_ctrl_t ctrl,
  input  logic [PW-1:0]       pos,
  input  logic [LEN_W-1:0]    len,
  input  wmf_pkg::sample_t    left_val,
  input  wmf_pkg::sample_t    right_val,
  output wmf_pkg::sample_t    val
);

  localparam logic ODD = ((IDX % 2) == 1);

  wmf_pkg::sample_t val_r, val_nxt;
  logic             is_lo, is_hi;

  // lower end of a pair: partner is right neighbor, must be inside the window
  assign is_lo = (ctrl.phase == ODD) && (LEN_W'(IDX + 1) < len);
  // upper end of a pair: partner is left neighbor
  assign is_hi = (ctrl.phase != ODD) && (IDX >= 1) && (LEN_W'(IDX) < len);

  always_comb begin
    val_nxt = val_r;
    if (ctrl.load && (pos == PW'(IDX))) begin
      val_nxt = ctrl.sample;
    end else if (ctrl.sort && is_lo) begin
      val_nxt = (val_r > right_val) ? right_val : val_r;
    end else if (ctrl.sort && is_hi) begin
      val_nxt = (left_val > val_r) ? left_val : val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

>>> src/window_median_filter_core.sv
// ----------------------------------------------------------------------------
// window_median_filter_core
// Sliding-window median filter over signed 16-bit samples.
// ----------------------------------------------------------------------------
// A sample word is written into the row of cells at the ring write position.
// A query word sorts the window in place with an odd-even transposition
// sort, one phase per cycle across the row of cells, then picks the middle
// entry into the output register; the block takes no new word until the
// median has been loaded into the output register. When disabled, samples
// are dropped and a query returns 0. The store clears at reset.
// ----------------------------------------------------------------------------
module window_median_filter_core #(
  parameter int MAX_WINDOW = wmf_pkg::DEF_MAX_WINDOW
) (
  input  logic                             clk,
  input  logic                             rst_n,
  wmf_in_if.sink                           in_chan,
  wmf_out_if.source                        out_chan,
  input  logic                             cfg_we,
  input  logic [wmf_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [wmf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int PW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_RAW = $clog2(MAX_WINDOW + 1);
  localparam int LEN_W   = (LEN_RAW > wmf_pkg::WLEN_W) ? LEN_RAW : wmf_pkg::WLEN_W;
  localparam int XW      = LEN_W + PW;

  // configuration
  logic                       enabled_r;
  logic [wmf_pkg::WLEN_W-1:0] wlen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      wlen_r    <= wmf_pkg::WLEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        wmf_pkg::CFG_ENABLED:    enabled_r <= cfg_wdata[0];
        wmf_pkg::CFG_WINDOW_LEN: wlen_r    <= cfg_wdata[wmf_pkg::WLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective length: zero reads as one, saturate at store depth
  logic [LEN_W-1:0] len_one, len_eff;
  assign len_one = (wlen_r == '0) ? LEN_W'(1) : LEN_W'(wlen_r);
  assign len_eff = (len_one > LEN_W'(MAX_WINDOW)) ? LEN_W'(MAX_WINDOW) : len_one;

  // sequencer
  wmf_pkg::state_t     state_r, state_nxt;
  logic [LEN_W-1:0]    cnt_r, cnt_nxt;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic                zero_r, zero_nxt;
  logic                out_valid_r, out_valid_nxt;
  wmf_pkg::sample_t    out_med_r, out_med_nxt;
  wmf_pkg::cell_ctrl_t ctrl;
  logic                in_acc;
  logic                out_free;
  logic [XW-1:0]       pos_inc;
  logic [XW-1:0]       mid_full;
  logic [PW-1:0]       mid_idx;
  wmf_pkg::sample_t    vals [MAX_WINDOW];

  assign in_chan.ready = (state_r == wmf_pkg::ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  assign pos_inc  = XW'(pos_r) + XW'(1);
  assign mid_full = XW'(XW'(len_eff) / wmf_pkg::MEDIAN_DIV);
  assign mid_idx  = mid_full[PW-1:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r;
    out_med_nxt   = out_med_r;
    ctrl.load     = 1'b0;
    ctrl.sort     = 1'b0;
    ctrl.phase    = cnt_r[0];
    ctrl.sample   = in_chan.sample_value;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      wmf_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.action == wmf_pkg::ACT_SAMPLE) begin
            if (enabled_r) begin
              ctrl.load = 1'b1;
              pos_nxt   = (pos_inc >= XW'(len_eff)) ? '0 : pos_inc[PW-1:0];
            end
          end else if (enabled_r) begin
            zero_nxt  = 1'b0;
            cnt_nxt   = '0;
            state_nxt = wmf_pkg::ST_SORT;
          end else begin
            zero_nxt  = 1'b1;
            state_nxt = wmf_pkg::ST_EMIT;
          end
        end
      end
      wmf_pkg::ST_SORT: begin
        ctrl.sort = 1'b1;
        cnt_nxt   = cnt_r + LEN_W'(1);
        if (cnt_r == len_eff - LEN_W'(1)) begin
          pos_nxt   = '0;
          state_nxt = wmf_pkg::ST_EMIT;
        end
      end
      wmf_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_med_nxt   = zero_r ? '0 : vals[mid_idx];
          state_nxt     = wmf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wmf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wmf_pkg::ST_IDLE;
      cnt_r       <= '0;
      pos_r       <= '0;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      zero_r      <= zero_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_med_r <= out_med_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.median_value = out_med_r;

  // row of cells; end cells see themselves as the missing neighbor
  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    wmf_pkg::sample_t lv, rv;
    if (g == 0) begin : g_l0
      assign lv = vals[g];
    end else begin : g_ln
      assign lv = vals[g-1];
    end
    if (g == MAX_WINDOW - 1) begin : g_rl
      assign rv = vals[g];
    end else begin : g_rn
      assign rv = vals[g+1];
    end

    wmf_cell #(
      .IDX   (g),
      .PW    (PW),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .pos       (pos_r),
      .len       (len_eff),
      .left_val  (lv),
      .right_val (rv),
      .val       (vals[g])
    );
  end

endmodule
